// File: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int VALUE_W = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODULUS  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RESET_EXPONENT = 32'd65537;
  localparam logic [CFG_DATA_W-1:0] RESET_MODULUS  = 32'd309485009;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP,
    ST_MULT,
    ST_FINISH
  } mexp_state_t;

  typedef struct packed {
    logic start;
    logic out_ready;
  } mexp_ctrl_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
  } mexp_stat_t;

endpackage

// File: rtl/mexp_in_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation input channel
// Valid/ready channel that carries one base value per transfer.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::VALUE_W-1:0] base_value;

  modport source (output valid, output base_value, input ready);
  modport sink (input valid, input base_value, output ready);
endinterface

// File: rtl/mexp_out_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation result channel
// Valid/ready channel that carries one result value per transfer.
// ----------------------------------------------------------------------------
interface mexp_out_if;
  logic                         valid;
  logic                         ready;
  logic [mexp_pkg::VALUE_W-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink (input valid, input result_value, output ready);
endinterface

// File: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises each base value to a configured exponent modulo a configured modulus.
// ----------------------------------------------------------------------------
// The input channel carries one base value per transfer and the result channel
// returns exactly one result value per base, in order. The user must write the
// exponent and the modulus through the cfg_ port only while the block is idle;
// the block itself does not enforce this. The block works on one base at a
// time and is not ready during the work. The base is first reduced modulo the
// modulus bit by bit. Each exponent bit up to the highest set bit then costs
// one modular squaring and, for a set bit, one modular product; each product
// is computed bit-serially over the multiplier on a shared modular add and
// double step. A zero exponent or a zero modulus skips the reduction and the
// products and goes straight to the finish state.
// Reset restores the default exponent and modulus and empties the block.
// A finished result waits in an output register while the receiver stalls,
// and the next base is already accepted meanwhile.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  mexp_in_if.sink                               in_if,
  mexp_out_if.source                            out_if,
  input  logic                                  cfg_we,
  input  logic [mexp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mexp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int W  = OPERAND_WIDTH;
  localparam int EW = (W > mexp_pkg::VALUE_W) ? W : mexp_pkg::VALUE_W;
  localparam logic [EW-1:0] EXP_RST = EW'(mexp_pkg::RESET_EXPONENT);
  localparam logic [EW-1:0] MOD_RST = EW'(mexp_pkg::RESET_MODULUS);

  logic [W-1:0]  exp_r, exp_nxt;
  logic [W-1:0]  mod_r, mod_nxt;
  logic [EW-1:0] wdata_ext;
  logic [EW-1:0] base_ext;
  logic [EW-1:0] result_ext;
  logic [W-1:0]  core_result;

  mexp_pkg::mexp_ctrl_t ctrl;
  mexp_pkg::mexp_stat_t stat;

  assign wdata_ext = EW'(cfg_wdata);

  always_comb begin
    exp_nxt = exp_r;
    mod_nxt = mod_r;
    if (cfg_we) begin
      case (cfg_index)
        mexp_pkg::REG_EXPONENT: exp_nxt = wdata_ext[W-1:0];
        mexp_pkg::REG_MODULUS:  mod_nxt = wdata_ext[W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= EXP_RST[W-1:0];
      mod_r <= MOD_RST[W-1:0];
    end else begin
      exp_r <= exp_nxt;
      mod_r <= mod_nxt;
    end
  end

  assign base_ext       = EW'(in_if.base_value);
  assign ctrl.start     = in_if.valid && stat.in_ready;
  assign ctrl.out_ready = out_if.ready;

  mexp_core #(.W(W)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .stat     (stat),
    .base     (base_ext[W-1:0]),
    .exponent (exp_r),
    .modulus  (mod_r),
    .result   (core_result)
  );

  assign result_ext          = EW'(core_result);
  assign in_if.ready         = stat.in_ready;
  assign out_if.valid        = stat.out_valid;
  assign out_if.result_value = result_ext[mexp_pkg::VALUE_W-1:0];

endmodule

// File: rtl/mexp_modadd.sv
// ----------------------------------------------------------------------------
// Modular adder
// Returns (a + b + cin) mod m for a and b below m, with one compare and subtract.
// ----------------------------------------------------------------------------
module mexp_modadd #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         cin,
  input  logic [W-1:0] m,
  output logic [W-1:0] y
);

  logic [W:0] sum;
  logic [W:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b} + {{W{1'b0}}, cin};
  assign diff = sum - {1'b0, m};
  assign y    = (sum >= {1'b0, m}) ? diff[W-1:0] : sum[W-1:0];

endmodule

// File: rtl/mexp_core.sv
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Sequencer around a shared modular add/double step: base reduction, then
// right-to-left square-and-multiply with bit-serial modular products.
// ----------------------------------------------------------------------------
module mexp_core #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mexp_pkg::mexp_ctrl_t ctrl,
  output mexp_pkg::mexp_stat_t stat,
  input  logic [W-1:0]        base,
  input  logic [W-1:0]        exponent,
  input  logic [W-1:0]        modulus,
  output logic [W-1:0]        result
);

  localparam int CW = $clog2(W + 1);

  mexp_pkg::mexp_state_t state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          sel_sq_r, sel_sq_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [W-1:0]  m_r, m_nxt;
  logic [W-1:0]  res_r, res_nxt;
  logic [W-1:0]  bas_r, bas_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  mb_r, mb_nxt;
  logic [W-1:0]  out_r, out_nxt;
  logic [W-1:0]  add_y;
  logic [W-1:0]  dbl_y;
  logic          dbl_cin;

  assign dbl_cin = (state_r == mexp_pkg::ST_REDUCE) && mb_r[W-1];

  mexp_modadd #(.W(W)) u_add (
    .a   (acc_r),
    .b   (a_r),
    .cin (1'b0),
    .m   (m_r),
    .y   (add_y)
  );

  mexp_modadd #(.W(W)) u_dbl (
    .a   (a_r),
    .b   (a_r),
    .cin (dbl_cin),
    .m   (m_r),
    .y   (dbl_y)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    sel_sq_nxt    = sel_sq_r;
    cnt_nxt       = cnt_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    res_nxt       = res_r;
    bas_nxt       = bas_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    mb_nxt        = mb_r;
    out_nxt       = out_r;

    if (out_valid_r && ctrl.out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (ctrl.start) begin
          e_nxt = exponent;
          m_nxt = modulus;
          if (exponent == '0) begin
            res_nxt   = W'(1);
            state_nxt = mexp_pkg::ST_FINISH;
          end else if (modulus == '0) begin
            res_nxt   = '0;
            state_nxt = mexp_pkg::ST_FINISH;
          end else begin
            a_nxt     = '0;
            mb_nxt    = base;
            cnt_nxt   = CW'(W);
            state_nxt = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        a_nxt   = dbl_y;
        mb_nxt  = {mb_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          bas_nxt   = dbl_y;
          res_nxt   = (m_r == W'(1)) ? '0 : W'(1);
          state_nxt = mexp_pkg::ST_EXP;
        end
      end
      mexp_pkg::ST_EXP: begin
        acc_nxt = '0;
        a_nxt   = bas_r;
        if (e_r == '0) begin
          state_nxt = mexp_pkg::ST_FINISH;
        end else if (e_r[0]) begin
          mb_nxt     = res_r;
          sel_sq_nxt = 1'b0;
          e_nxt      = {e_r[W-1:1], 1'b0};
          state_nxt  = mexp_pkg::ST_MULT;
        end else begin
          mb_nxt     = bas_r;
          sel_sq_nxt = 1'b1;
          e_nxt      = e_r >> 1;
          state_nxt  = mexp_pkg::ST_MULT;
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mb_r == '0) begin
          if (sel_sq_r) begin
            bas_nxt = acc_r;
          end else begin
            res_nxt = acc_r;
          end
          state_nxt = mexp_pkg::ST_EXP;
        end else begin
          acc_nxt = mb_r[0] ? add_y : acc_r;
          a_nxt   = dbl_y;
          mb_nxt  = mb_r >> 1;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid_r || ctrl.out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_sq_r <= sel_sq_nxt;
    cnt_r    <= cnt_nxt;
    e_r      <= e_nxt;
    m_r      <= m_nxt;
    res_r    <= res_nxt;
    bas_r    <= bas_nxt;
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    mb_r     <= mb_nxt;
    out_r    <= out_nxt;
  end

  assign stat.in_ready  = (state_r == mexp_pkg::ST_IDLE);
  assign stat.out_valid = out_valid_r;
  assign result         = out_r;

endmodule

// File: tb/modular_exponentiation_tb.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base values over the input channel under several exponent and
// modulus settings, first from a directed table and then at random. Every
// transfer on the result channel is checked against a stored table answer or
// a model of square-and-multiply exponentiation. Both channels idle at random.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS  = 270;
  localparam int QUIET_LIMIT  = 15000;
  localparam int MAX_REPORTS  = 10;

  typedef logic [mexp_pkg::VALUE_W-1:0] value_t;

  localparam value_t RST_EXP = mexp_pkg::RESET_EXPONENT;
  localparam value_t RST_MOD = mexp_pkg::RESET_MODULUS;

  typedef struct {
    value_t exponent;
    value_t modulus;
    value_t base;
    logic   fixed;
    value_t answer;
  } table_row_t;

  typedef struct {
    logic   fixed;
    value_t answer;
  } fixed_note_t;

  logic clk;
  logic rst_n;
  logic                             cfg_we;
  logic [mexp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [mexp_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  modular_exponentiation DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  value_t      pending_results[$];
  fixed_note_t fixed_notes[$];
  value_t      dut_exponent;
  value_t      dut_modulus;
  value_t      cur_exponent;
  value_t      cur_modulus;
  int          errors;
  int          quiet_cycles;
  int          items_sent;
  bit          no_idle;
  table_row_t  rows[21];

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Right-to-left square-and-multiply with exact double-width products.
  function automatic value_t power_mod(input value_t b, input value_t e, input value_t m);
    logic [2*mexp_pkg::VALUE_W-1:0] acc;
    logic [2*mexp_pkg::VALUE_W-1:0] sq;
    value_t                         bits;
    if (e == '0) return value_t'(1);
    if (m == '0) return '0;
    acc  = 64'd1 % m;
    sq   = b % m;
    bits = e;
    while (bits != '0) begin
      if (bits[0]) acc = (acc * sq) % m;
      sq   = (sq * sq) % m;
      bits = bits >> 1;
    end
    return acc[mexp_pkg::VALUE_W-1:0];
  endfunction

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Checks results, predicts accepted bases and tracks the register values.
  always @(posedge clk) begin
    value_t want;
    fixed_note_t note;
    if (!rst_n) begin
      dut_exponent = RST_EXP;
      dut_modulus  = RST_MOD;
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (cfg_we) begin
        quiet_cycles = 0;
        if (cfg_index == mexp_pkg::REG_EXPONENT) dut_exponent = cfg_wdata;
        else if (cfg_index == mexp_pkg::REG_MODULUS) dut_modulus = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        if (pending_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS)
            $display("Unexpected result transfer: actual %h", out_ch.result_value);
        end else begin
          want = pending_results.pop_front();
          if (out_ch.result_value !== want) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS)
              $display("Mismatch on result_value: expected %h, actual %h",
                       want, out_ch.result_value);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        quiet_cycles = 0;
        note = fixed_notes.pop_front();
        if (note.fixed) pending_results.push_back(note.answer);
        else pending_results.push_back(power_mod(in_ch.base_value, dut_exponent, dut_modulus));
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Entered at a rising edge; returns at the edge of the transfer with valid high.
  task automatic send_item(input value_t base, input logic fixed, input value_t answer);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_value <= base;
    fixed_notes.push_back('{fixed, answer});
    do @(posedge clk); while (!in_ch.ready);
    items_sent = items_sent + 1;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0 || fixed_notes.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_settings(input value_t e, input value_t m);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= mexp_pkg::REG_EXPONENT;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= mexp_pkg::REG_MODULUS;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_exponent = e;
    cur_modulus  = m;
  endtask

  initial begin
    value_t e;
    value_t m;
    value_t b;
    int     count;
    errors       = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    cur_exponent = RST_EXP;
    cur_modulus  = RST_MOD;

    rows[0]  = '{RST_EXP, RST_MOD, 32'h0000_0000, 1'b1, 32'h0000_0000};
    rows[1]  = '{RST_EXP, RST_MOD, 32'h0000_0001, 1'b1, 32'h0000_0001};
    rows[2]  = '{RST_EXP, RST_MOD, 32'hFFFF_FFFF, 1'b0, 32'h0};
    rows[3]  = '{RST_EXP, RST_MOD, RST_MOD,       1'b1, 32'h0000_0000};
    rows[4]  = '{RST_EXP, RST_MOD, 32'd12345,     1'b0, 32'h0};
    rows[5]  = '{32'd0, RST_MOD,       32'hFFFF_FFFF, 1'b1, 32'h0000_0001};
    rows[6]  = '{32'd0, 32'd1,         32'd5,         1'b1, 32'h0000_0001};
    rows[7]  = '{32'd0, 32'd0,         32'd7,         1'b1, 32'h0000_0001};
    rows[8]  = '{32'd5, 32'd1,         32'hFFFF_FFFF, 1'b1, 32'h0000_0000};
    rows[9]  = '{32'hFFFF_FFFF, 32'd1, 32'd3,         1'b1, 32'h0000_0000};
    rows[10] = '{32'd3, 32'd0,         32'd9,         1'b1, 32'h0000_0000};
    rows[11] = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE};
    rows[12] = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000};
    rows[13] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'h0};
    rows[14] = '{32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'hABCD_EF01, 1'b0, 32'h0};
    rows[15] = '{32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001};
    rows[16] = '{32'h8000_0000, 32'd1000003, 32'd2,   1'b0, 32'h0};
    rows[17] = '{RST_EXP, 32'd2, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001};
    rows[18] = '{RST_EXP, 32'd2, 32'h8000_0000, 1'b1, 32'h0000_0000};
    rows[19] = '{32'hFFFF_FFFF, 32'h8000_0000, 32'd3, 1'b0, 32'h0};
    rows[20] = '{32'h5555_5555, 32'hAAAA_AAAB, 32'h1234_5678, 1'b0, 32'h0};

    in_ch.valid      <= 1'b0;
    in_ch.base_value <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= mexp_pkg::REG_EXPONENT;
    cfg_wdata        <= '0;
    rst_n            <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].exponent != cur_exponent || rows[i].modulus != cur_modulus)
        load_settings(rows[i].exponent, rows[i].modulus);
      send_item(rows[i].base, rows[i].fixed, rows[i].answer);
    end

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       e = '0;
        1:       e = 32'hFFFF_FFFF;
        2, 3, 4: e = $urandom >> $urandom_range(16, 31);
        default: e = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       m = 32'd1;
        1:       m = 32'hFFFF_FFFF;
        2:       m = $urandom_range(2, 1000);
        3:       m = $urandom | 32'h8000_0000;
        default: m = $urandom;
      endcase
      if (m == '0) m = 32'd1;
      load_settings(e, m);
      no_idle = ($urandom_range(0, 3) == 0);
      count = $urandom_range(8, 24);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 19) == 0) wait_drained();
        case ($urandom_range(0, 9))
          0:       b = '0;
          1:       b = 32'hFFFF_FFFF;
          2:       b = m - 32'd1;
          3:       b = m;
          4:       b = $urandom_range(0, 15);
          default: b = $urandom;
        endcase
        send_item(b, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (20) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mexp_pkg.sv
rtl/mexp_in_if.sv
rtl/mexp_out_if.sv
rtl/mexp_modadd.sv
rtl/mexp_core.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
